### sv/mvi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mvi_pkg;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [1:0] {
      KIND_TRAIN  = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_APPLY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EMPTY       = 2'd1,
      STATUS_ZERO_WEIGHT = 2'd2,
      STATUS_OVERFLOW    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_MODE         = 3'd0,
      REG_CLASS_BLIND  = 3'd1,
      REG_CLASS_COUNT  = 3'd2,
      REG_CHOSEN_CLASS = 3'd3,
      REG_DIMS_USED    = 3'd4,
      REG_RANGE_ENABLE = 3'd5,
      REG_RANGE_LOW    = 3'd6,
      REG_RANGE_HIGH   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      PASS_TOTAL  = 2'd0,
      PASS_SEARCH = 2'd1,
      PASS_FIND   = 2'd2,
      PASS_SUM    = 2'd3
   } pass_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_ENTRY  = 3'd1,
      ST_TOTAL  = 3'd2,
      ST_SEARCH = 3'd3,
      ST_FIND   = 3'd4,
      ST_SUM    = 3'd5,
      ST_DIV    = 3'd6
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         dim_index;
      logic signed [31:0] value;
      logic [31:0]        weight;
      logic [1:0]         class_index;
      logic               end_of_vector;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         result_dim;
      logic [1:0]         result_class;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               mode;
      logic               class_blind;
      logic [2:0]         class_count;
      logic [1:0]         chosen_class;
      logic [2:0]         dims_used;
      logic               range_enable;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic       pass_start;
      pass_type   pass_kind;
      logic       search_commit;
      logic       div_start;
      logic       emit;
      status_type emit_status;
      logic       next_entry;
      logic       finish_end;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic div_done;
      logic bit_zero;
      logic last_entry;
      logic overflow;
      logic none_selected;
      logic total_zero;
   } stat_type;

endpackage
`default_nettype wire

### sv/mvi_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module mvi_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mvi_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  wire logic [mvi_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic      [mvi_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                     csr_pready,
   output mvi_pkg::cfg_type                         cfg
);

   mvi_pkg::cfg_type      cfg_ff, cfg_in;
   mvi_pkg::reg_index_type reg_index;
   logic                  write_go;

   assign csr_pready = 1'b1;
   assign reg_index  = mvi_pkg::reg_index_type'(csr_paddr[4:2]);
   assign write_go   = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_go) begin
         case (reg_index)
            mvi_pkg::REG_MODE:         cfg_in.mode         = csr_pwdata[0];
            mvi_pkg::REG_CLASS_BLIND:  cfg_in.class_blind  = csr_pwdata[0];
            mvi_pkg::REG_CLASS_COUNT:  cfg_in.class_count  = csr_pwdata[2:0];
            mvi_pkg::REG_CHOSEN_CLASS: cfg_in.chosen_class = csr_pwdata[1:0];
            mvi_pkg::REG_DIMS_USED:    cfg_in.dims_used    = csr_pwdata[2:0];
            mvi_pkg::REG_RANGE_ENABLE: cfg_in.range_enable = csr_pwdata[0];
            mvi_pkg::REG_RANGE_LOW:    cfg_in.range_low    = csr_pwdata;
            mvi_pkg::REG_RANGE_HIGH:   cfg_in.range_high   = csr_pwdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         mvi_pkg::REG_MODE:         csr_prdata = {31'd0, cfg_ff.mode};
         mvi_pkg::REG_CLASS_BLIND:  csr_prdata = {31'd0, cfg_ff.class_blind};
         mvi_pkg::REG_CLASS_COUNT:  csr_prdata = {29'd0, cfg_ff.class_count};
         mvi_pkg::REG_CHOSEN_CLASS: csr_prdata = {30'd0, cfg_ff.chosen_class};
         mvi_pkg::REG_DIMS_USED:    csr_prdata = {29'd0, cfg_ff.dims_used};
         mvi_pkg::REG_RANGE_ENABLE: csr_prdata = {31'd0, cfg_ff.range_enable};
         mvi_pkg::REG_RANGE_LOW:    csr_prdata = cfg_ff.range_low;
         mvi_pkg::REG_RANGE_HIGH:   csr_prdata = cfg_ff.range_high;
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= 1'b0;
         cfg_ff.class_blind  <= 1'b1;
         cfg_ff.class_count  <= 3'd1;
         cfg_ff.chosen_class <= 2'd0;
         cfg_ff.dims_used    <= 3'd4;
         cfg_ff.range_enable <= 1'b0;
         cfg_ff.range_low    <= '0;
         cfg_ff.range_high   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### sv/mvi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mvi_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        req_kind,
   input  wire logic              range_enable,
   input  wire logic              mode,
   input  wire mvi_pkg::stat_type stat,
   output mvi_pkg::cmd_type       cmd,
   output logic                   busy
);

   mvi_pkg::state_type state_ff, state_in;
   mvi_pkg::state_type after_emit;
   logic               is_finish;

   assign is_finish  = (mvi_pkg::kind_type'(req_kind) == mvi_pkg::KIND_FINISH);
   assign after_emit = stat.last_entry ? mvi_pkg::ST_IDLE : mvi_pkg::ST_ENTRY;
   assign busy       = (state_ff != mvi_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mvi_pkg::ST_IDLE: begin
            if (start && is_finish && range_enable) state_in = mvi_pkg::ST_ENTRY;
         end
         mvi_pkg::ST_ENTRY: begin
            state_in = stat.overflow ? after_emit : mvi_pkg::ST_TOTAL;
         end
         mvi_pkg::ST_TOTAL: begin
            if (stat.pass_done) begin
               if (stat.none_selected || stat.total_zero) state_in = after_emit;
               else state_in = mode ? mvi_pkg::ST_SUM : mvi_pkg::ST_SEARCH;
            end
         end
         mvi_pkg::ST_SEARCH: begin
            if (stat.pass_done && stat.bit_zero) state_in = mvi_pkg::ST_FIND;
         end
         mvi_pkg::ST_FIND: begin
            if (stat.pass_done) state_in = after_emit;
         end
         mvi_pkg::ST_SUM: begin
            if (stat.pass_done) state_in = mvi_pkg::ST_DIV;
         end
         mvi_pkg::ST_DIV: begin
            if (stat.div_done) state_in = after_emit;
         end
         default: state_in = mvi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.pass_kind   = mvi_pkg::PASS_TOTAL;
      cmd.emit_status = mvi_pkg::STATUS_OK;
      case (state_ff)
         mvi_pkg::ST_IDLE: begin
            cmd.accept     = start;
            cmd.finish_end = start && is_finish && !range_enable;
         end
         mvi_pkg::ST_ENTRY: begin
            if (stat.overflow) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = mvi_pkg::STATUS_OVERFLOW;
            end else begin
               cmd.pass_start = 1'b1;
               cmd.pass_kind  = mvi_pkg::PASS_TOTAL;
            end
         end
         mvi_pkg::ST_TOTAL: begin
            if (stat.pass_done) begin
               if (stat.none_selected) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = mvi_pkg::STATUS_EMPTY;
               end else if (stat.total_zero) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = mvi_pkg::STATUS_ZERO_WEIGHT;
               end else begin
                  cmd.pass_start = 1'b1;
                  cmd.pass_kind  = mode ? mvi_pkg::PASS_SUM : mvi_pkg::PASS_SEARCH;
               end
            end
         end
         mvi_pkg::ST_SEARCH: begin
            if (stat.pass_done) begin
               cmd.search_commit = 1'b1;
               cmd.pass_start    = 1'b1;
               cmd.pass_kind     = stat.bit_zero ? mvi_pkg::PASS_FIND : mvi_pkg::PASS_SEARCH;
            end
         end
         mvi_pkg::ST_FIND: begin
            cmd.emit = stat.pass_done;
         end
         mvi_pkg::ST_SUM: begin
            cmd.div_start = stat.pass_done;
         end
         mvi_pkg::ST_DIV: begin
            cmd.emit = stat.div_done;
         end
         default: cmd = '0;
      endcase
      if (cmd.emit) begin
         cmd.next_entry = !stat.last_entry;
         cmd.finish_end = stat.last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### sv/mvi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mvi_datapath #(
   parameter int MAX_SAMPLES = 1024,
   parameter int MAX_DIMS    = 4,
   parameter int MAX_CLASSES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mvi_pkg::cfg_type cfg,
   input  wire mvi_pkg::cmd_type cmd,
   input  wire mvi_pkg::req_type req_data,
   output mvi_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output mvi_pkg::rsp_type      rsp_data
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int VD  = MAX_SAMPLES * MAX_DIMS;
   localparam int VAW = (VD > 1) ? $clog2(VD) : 1;
   localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CLW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int TW  = 32 + CW;
   localparam int SW  = 64 + CW;
   localparam int MW  = MAX_DIMS + 34;
   localparam int DCW = $clog2(SW + 1);

   logic [31:0]        val_mem [VD];
   logic [MW-1:0]      meta_mem [MAX_SAMPLES];
   logic signed [31:0] val_rd_ff;
   logic [MW-1:0]      meta_rd_ff;

   logic [CW-1:0]        count_ff, count_in;
   logic                 open_ff, open_in;
   logic [MAX_DIMS-1:0]  mask_ff, mask_in;
   logic                 overflow_ff, overflow_in;
   logic                 trained_ff, trained_in;
   logic signed [31:0]   rep_table_ff [MAX_DIMS][MAX_CLASSES];
   logic signed [31:0]   rep_table_in [MAX_DIMS][MAX_CLASSES];
   logic [1:0]           d_ff, d_in, c_ff, c_in;
   logic                 scanning_ff, scanning_in;
   logic [CW-1:0]        scan_idx_ff, scan_idx_in;
   mvi_pkg::pass_type    kind_ff, kind_in;
   logic                 v1_ff, v1_in, v2_ff, v2_in;
   logic [TW-1:0]        total_ff, total_in;
   logic                 any_ff, any_in;
   logic [TW-1:0]        wle_ff, wle_in;
   logic [31:0]          prefix_ff, prefix_in;
   logic [4:0]           bit_ff, bit_in;
   logic [TW-1:0]        lt_ff, lt_in;
   logic                 has_lt_ff, has_lt_in;
   logic signed [31:0]   pred_ff, pred_in;
   logic                 found_ff, found_in;
   logic [31:0]          wfirst_ff, wfirst_in;
   logic [63:0]          prod_ff, prod_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [SW-1:0]        dvd_ff, dvd_in;
   logic [TW-1:0]        rem_ff, rem_in;
   logic [31:0]          quo_ff, quo_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic                 dact_ff, dact_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mvi_pkg::rsp_type     rsp_ff, rsp_in;

   logic [2:0]           nd, nc, cl_n;
   logic                 accept_train, accept_apply, accept_finish;
   logic                 full, dim_ok;
   logic [MAX_DIMS-1:0]  mask_new;
   logic                 meta_we, val_we;
   logic [AW-1:0]        meta_waddr, meta_raddr;
   logic [VAW-1:0]       val_waddr, val_raddr;
   logic                 issue, pass_done, div_done, last_entry;
   logic signed [31:0]   val_eff, med, thr;
   logic [31:0]          thr_u, w_rd;
   logic [1:0]           cls_rd;
   logic [MAX_DIMS-1:0]  mask_rd;
   logic                 sel;
   logic [63:0]          mul;
   logic [TW:0]          rem_sh, lt_wf;
   logic                 cross_first;
   logic signed [32:0]   pair_sum;
   logic signed [31:0]   median, mean, emit_value;
   logic [1:0]           tcls;
   logic signed [31:0]   apply_value;

   always_comb begin
      nd = cfg.dims_used;
      if (nd == 3'd0) nd = 3'd1;
      if (nd > 3'd4) nd = 3'd4;
      if (32'(nd) > MAX_DIMS) nd = 3'(MAX_DIMS);
      nc = cfg.class_count;
      if (nc == 3'd0) nc = 3'd1;
      if (nc > 3'd4) nc = 3'd4;
      if (32'(nc) > MAX_CLASSES) nc = 3'(MAX_CLASSES);
      cl_n = cfg.class_blind ? 3'd1 : nc;
   end

   assign accept_train  = cmd.accept && (mvi_pkg::kind_type'(req_data.kind) == mvi_pkg::KIND_TRAIN);
   assign accept_finish = cmd.accept && (mvi_pkg::kind_type'(req_data.kind) == mvi_pkg::KIND_FINISH);
   assign accept_apply  = cmd.accept && (mvi_pkg::kind_type'(req_data.kind) == mvi_pkg::KIND_APPLY);
   assign full          = (count_ff >= CW'(MAX_SAMPLES));
   assign dim_ok        = ({30'd0, req_data.dim_index} < 32'(MAX_DIMS));
   assign mask_new      = (open_ff ? mask_ff : '0)
                        | (dim_ok ? (MAX_DIMS'(1) << req_data.dim_index) : '0);
   assign meta_we       = accept_train && !full;
   assign val_we        = meta_we && dim_ok;
   assign meta_waddr    = AW'(count_ff);
   assign val_waddr     = VAW'(VAW'(count_ff) * VAW'(MAX_DIMS)) + VAW'(req_data.dim_index);
   assign meta_raddr    = AW'(scan_idx_ff);
   assign val_raddr     = VAW'(VAW'(scan_idx_ff) * VAW'(MAX_DIMS)) + VAW'(d_ff);

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= {mask_new, req_data.class_index, req_data.weight};
      if (val_we) val_mem[val_waddr] <= req_data.value;
      meta_rd_ff <= meta_mem[meta_raddr];
      val_rd_ff  <= val_mem[val_raddr];
   end

   assign issue      = scanning_ff && (scan_idx_ff != count_ff);
   assign pass_done  = scanning_ff && !issue && !v1_ff && !v2_ff;
   assign div_done   = dact_ff && (dcnt_ff == '0);
   assign last_entry = ({1'b0, d_ff} == nd - 3'd1) && ({1'b0, c_ff} == cl_n - 3'd1);

   assign w_rd    = meta_rd_ff[31:0];
   assign cls_rd  = meta_rd_ff[33:32];
   assign mask_rd = meta_rd_ff[MW-1:34];
   assign val_eff = mask_rd[DW'(d_ff)] ? val_rd_ff : 32'sd0;
   assign sel     = v1_ff && (cfg.class_blind || (cls_rd == c_ff))
                  && (val_eff > cfg.range_low) && (val_eff < cfg.range_high);
   assign mul     = w_rd * (val_eff ^ 32'h8000_0000);
   assign med     = prefix_ff ^ 32'h8000_0000;
   assign thr_u   = prefix_ff | ~(32'hFFFF_FFFF << bit_ff);
   assign thr     = thr_u ^ 32'h8000_0000;
   assign rem_sh  = {rem_ff, dvd_ff[SW-1]};

   assign lt_wf       = {1'b0, lt_ff} + {{(TW-31){1'b0}}, wfirst_ff};
   assign cross_first = {lt_wf, 1'b0} > {2'b00, total_ff};
   assign pair_sum    = {pred_ff[31], pred_ff} + {med[31], med};
   assign median      = (cross_first && has_lt_ff) ? pair_sum[32:1] : med;
   assign mean        = quo_ff ^ 32'h8000_0000;
   assign emit_value  = (cmd.emit_status != mvi_pkg::STATUS_OK) ? 32'sd0 :
                        (cfg.mode ? mean : median);

   always_comb begin
      tcls = cfg.class_blind ? 2'd0 : cfg.chosen_class;
      if ({1'b0, tcls} >= nc) tcls = 2'd0;
      apply_value = req_data.value;
      if (trained_ff && cfg.range_enable && dim_ok
          && !((req_data.value > cfg.range_low) && (req_data.value < cfg.range_high))) begin
         apply_value = rep_table_ff[DW'(req_data.dim_index)][CLW'(tcls)];
      end
   end

   always_comb begin
      count_in     = count_ff;
      open_in      = open_ff;
      mask_in      = mask_ff;
      overflow_in  = overflow_ff;
      trained_in   = trained_ff;
      rep_table_in = rep_table_ff;
      d_in         = d_ff;
      c_in         = c_ff;
      scanning_in  = scanning_ff;
      scan_idx_in  = scan_idx_ff;
      kind_in      = kind_ff;
      v1_in        = issue;
      v2_in        = v1_ff && (kind_ff == mvi_pkg::PASS_SUM);
      total_in     = total_ff;
      any_in       = any_ff;
      wle_in       = wle_ff;
      prefix_in    = prefix_ff;
      bit_in       = bit_ff;
      lt_in        = lt_ff;
      has_lt_in    = has_lt_ff;
      pred_in      = pred_ff;
      found_in     = found_ff;
      wfirst_in    = wfirst_ff;
      prod_in      = sel ? mul : 64'd0;
      sum_in       = sum_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      dact_in      = dact_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (accept_train) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            mask_in = mask_new;
            if (req_data.end_of_vector) begin
               count_in = count_ff + CW'(1);
               open_in  = 1'b0;
            end else begin
               open_in = 1'b1;
            end
         end
      end

      if (accept_apply) begin
         rsp_valid_in         = 1'b1;
         rsp_in.result_value  = apply_value;
         rsp_in.result_dim    = req_data.dim_index;
         rsp_in.result_class  = 2'd0;
         rsp_in.status        = mvi_pkg::STATUS_OK;
         rsp_in.last          = req_data.end_of_vector;
      end

      if (accept_finish) begin
         trained_in = cfg.range_enable;
         d_in       = 2'd0;
         c_in       = 2'd0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            for (int j = 0; j < MAX_CLASSES; j++) begin
               rep_table_in[i][j] = 32'sd0;
            end
         end
      end

      if (sel) begin
         case (kind_ff)
            mvi_pkg::PASS_TOTAL: begin
               total_in = total_ff + TW'(w_rd);
               any_in   = 1'b1;
            end
            mvi_pkg::PASS_SEARCH: begin
               if (val_eff <= thr) wle_in = wle_ff + TW'(w_rd);
            end
            mvi_pkg::PASS_FIND: begin
               if (val_eff < med) begin
                  lt_in     = lt_ff + TW'(w_rd);
                  has_lt_in = 1'b1;
                  if (!has_lt_ff || (val_eff > pred_ff)) pred_in = val_eff;
               end
               if ((val_eff == med) && !found_ff) begin
                  found_in  = 1'b1;
                  wfirst_in = w_rd;
               end
            end
            default: begin
            end
         endcase
      end
      if (v2_ff) sum_in = sum_ff + SW'(prod_ff);

      if (issue) scan_idx_in = scan_idx_ff + CW'(1);
      if (pass_done) scanning_in = 1'b0;

      if (cmd.search_commit) begin
         if (!({wle_ff, 1'b0} > {1'b0, total_ff})) prefix_in[bit_ff] = 1'b1;
         bit_in = bit_ff - 5'd1;
      end

      if (cmd.pass_start) begin
         scanning_in = 1'b1;
         scan_idx_in = '0;
         kind_in     = cmd.pass_kind;
         case (cmd.pass_kind)
            mvi_pkg::PASS_TOTAL: begin
               total_in  = '0;
               any_in    = 1'b0;
               prefix_in = '0;
               bit_in    = 5'd31;
            end
            mvi_pkg::PASS_SEARCH: wle_in = '0;
            mvi_pkg::PASS_FIND: begin
               lt_in     = '0;
               has_lt_in = 1'b0;
               found_in  = 1'b0;
               wfirst_in = '0;
            end
            mvi_pkg::PASS_SUM: sum_in = '0;
            default: sum_in = '0;
         endcase
      end

      if (dact_ff && (dcnt_ff != '0)) begin
         if (rem_sh >= {1'b0, total_ff}) begin
            rem_in = TW'(rem_sh - {1'b0, total_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[TW-1:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         dvd_in  = {dvd_ff[SW-2:0], 1'b0};
         dcnt_in = dcnt_ff - DCW'(1);
      end
      if (div_done) dact_in = 1'b0;
      if (cmd.div_start) begin
         dact_in = 1'b1;
         dvd_in  = sum_ff;
         rem_in  = '0;
         quo_in  = '0;
         dcnt_in = DCW'(SW);
      end

      if (cmd.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_value = emit_value;
         rsp_in.result_dim   = d_ff;
         rsp_in.result_class = c_ff;
         rsp_in.status       = cmd.emit_status;
         rsp_in.last         = last_entry;
         for (int j = 0; j < MAX_CLASSES; j++) begin
            if ((cfg.class_blind && (32'(j) < 32'(nc)))
                || (!cfg.class_blind && (32'(j) == 32'(c_ff)))) begin
               rep_table_in[DW'(d_ff)][j] = emit_value;
            end
         end
      end

      if (cmd.next_entry) begin
         if ({1'b0, c_ff} == cl_n - 3'd1) begin
            c_in = 2'd0;
            d_in = d_ff + 2'd1;
         end else begin
            c_in = c_ff + 2'd1;
         end
      end

      if (cmd.finish_end) begin
         count_in    = '0;
         overflow_in = 1'b0;
         open_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         open_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         trained_ff   <= 1'b0;
         scanning_ff  <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         dact_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            for (int j = 0; j < MAX_CLASSES; j++) begin
               rep_table_ff[i][j] <= 32'sd0;
            end
         end
      end else begin
         count_ff     <= count_in;
         open_ff      <= open_in;
         overflow_ff  <= overflow_in;
         trained_ff   <= trained_in;
         scanning_ff  <= scanning_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         dact_ff      <= dact_in;
         rsp_valid_ff <= rsp_valid_in;
         rep_table_ff <= rep_table_in;
      end
      mask_ff     <= mask_in;
      d_ff        <= d_in;
      c_ff        <= c_in;
      scan_idx_ff <= scan_idx_in;
      kind_ff     <= kind_in;
      total_ff    <= total_in;
      any_ff      <= any_in;
      wle_ff      <= wle_in;
      prefix_ff   <= prefix_in;
      bit_ff      <= bit_in;
      lt_ff       <= lt_in;
      has_lt_ff   <= has_lt_in;
      pred_ff     <= pred_in;
      found_ff    <= found_in;
      wfirst_ff   <= wfirst_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      rsp_ff      <= rsp_in;
   end

   assign stat.pass_done     = pass_done;
   assign stat.div_done      = div_done;
   assign stat.bit_zero      = (bit_ff == 5'd0);
   assign stat.last_entry    = last_entry;
   assign stat.overflow      = overflow_ff;
   assign stat.none_selected = !any_ff;
   assign stat.total_zero    = (total_ff == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### sv/missing_value_imputer_top.sv
// Channel    Ports                           Transfer
// request    start, busy, req_data           start high while busy low
// result     rsp_valid, rsp_data             each result shown for exactly one cycle, no stall
// config     csr_psel ... csr_pready (APB)   psel, penable, pwrite, pready high
//
// Items are accepted while busy is low; an apply result appears on the next cycle.
// With range checking enabled, a finish item walks the sample store once per pass.
// Per entry the median takes 34 passes, the mean two passes and a shift-subtract division.
// Synchronous active-high reset; no clearing pass, the store is tracked by a fill count.
// The receiver cannot stall, so busy only reflects a finish run in progress.
`timescale 1ns / 1ps
`default_nettype none
module missing_value_imputer_top #(
   parameter int MAX_SAMPLES = 1024,
   parameter int MAX_DIMS    = 4,
   parameter int MAX_CLASSES = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire mvi_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   output mvi_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mvi_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [mvi_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [mvi_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                  csr_pready
);

   mvi_pkg::cfg_type  cfg;
   mvi_pkg::cmd_type  cmd;
   mvi_pkg::stat_type stat;

   mvi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mvi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_kind     (req_data.kind),
      .range_enable (cfg.range_enable),
      .mode         (cfg.mode),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy)
   );

   mvi_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_DIMS    (MAX_DIMS),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### sv/mvi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mvi_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire mvi_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire mvi_pkg::rsp_type rsp_data
);

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != mvi_pkg::STATUS_OK) |-> rsp_data.result_value == 32'sd0)
      else $error("error result carries a nonzero value");

   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start transfer");

   a_apply_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.kind == mvi_pkg::KIND_APPLY) |=>
      rsp_valid && (rsp_data.status == mvi_pkg::STATUS_OK) && (rsp_data.result_class == 2'd0))
      else $error("apply transfer gave no plain result");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !busy && !rsp_valid)
      else $error("activity right after reset");

endmodule

bind missing_value_imputer_top mvi_checker u_mvi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

### test/missing_value_imputer_top_test.sv
`timescale 1ns / 1ps
module missing_value_imputer_top_test;
   import mvi_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int RANDOM_ITEMS = 420;
   localparam logic [31:0] ONE = 32'h0001_0000;

   typedef struct {
      bit            is_csr;
      reg_index_type reg_idx;
      logic [31:0]   csr_val;
      req_type       req;
      bit            typed;
      rsp_type       rsp;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   missing_value_imputer_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block's registers and training store.
   cfg_type            cfg_shadow;
   logic signed [31:0] stored_value [STORE_DEPTH][4];
   logic [31:0]        stored_weight [STORE_DEPTH];
   logic [1:0]         stored_class [STORE_DEPTH];
   int unsigned        stored_count;
   logic signed [31:0] imputation_table [4][4];
   bit                 is_trained;
   bit                 store_overflowed;
   bit                 vector_open;

   rsp_type awaited_results [$];
   rsp_type fresh_results [$];
   int      mismatch_count = 0;
   int      idle_pct = 0;
   int      items_sent = 0;
   longint  cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("Mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.result_value, 0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", rsp_data.result_value, want.result_value);
            if (rsp_data.result_dim !== want.result_dim)
               report_mismatch("result_dim", rsp_data.result_dim, want.result_dim);
            if (rsp_data.result_class !== want.result_class)
               report_mismatch("result_class", rsp_data.result_class, want.result_class);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   function automatic bit in_valid_range(logic signed [31:0] v);
      return $signed(v) > $signed(cfg_shadow.range_low) &&
             $signed(v) < $signed(cfg_shadow.range_high);
   endfunction

   function automatic int unsigned clamp_1_4(logic [2:0] n);
      if (n < 1) return 1;
      if (n > 4) return 4;
      return n;
   endfunction

   function automatic status_type impute_entry(int unsigned d, int unsigned c, bit pooled,
                                               output logic signed [31:0] res);
      logic signed [31:0] pv [$];
      logic [31:0]        pw [$];
      logic [95:0]        total;
      logic [95:0]        cum;
      logic [95:0]        acc;
      logic [95:0]        quot;
      logic signed [31:0] v;
      longint             pair;
      int                 j;
      int                 idx;
      total = 0;
      cum = 0;
      acc = 0;
      res = 0;
      for (int s = 0; s < stored_count; s++) begin
         if (!pooled && stored_class[s] != c) continue;
         v = stored_value[s][d];
         if (!in_valid_range(v)) continue;
         j = pv.size();
         while (j > 0 && $signed(pv[j-1]) > $signed(v)) j--;
         pv.insert(j, v);
         pw.insert(j, stored_weight[s]);
      end
      if (pv.size() == 0) return STATUS_EMPTY;
      foreach (pw[i]) total += 96'(pw[i]);
      if (total == 0) return STATUS_ZERO_WEIGHT;
      if (cfg_shadow.mode == 1'b0) begin
         idx = pv.size() - 1;
         for (int i = 0; i < pv.size(); i++) begin
            cum += 96'(pw[i]);
            if (2 * cum > total) begin
               idx = i;
               break;
            end
         end
         if (idx == 0) begin
            res = pv[0];
         end else begin
            pair = longint'($signed(pv[idx])) + longint'($signed(pv[idx-1]));
            res = 32'(pair >>> 1);
         end
      end else begin
         foreach (pv[i]) acc += 96'(pw[i]) * 96'(pv[i] ^ 32'h8000_0000);
         quot = acc / total;
         res = quot[31:0] ^ 32'h8000_0000;
      end
      return STATUS_OK;
   endfunction

   function automatic void predict_item(req_type r);
      int unsigned        nd;
      int unsigned        nc;
      int unsigned        cl_n;
      int unsigned        c;
      logic signed [31:0] v;
      status_type         st;
      rsp_type            o;
      case (r.kind)
         KIND_TRAIN: begin
            if (stored_count >= STORE_DEPTH) begin
               store_overflowed = 1;
            end else begin
               if (!vector_open) begin
                  for (int d = 0; d < 4; d++) stored_value[stored_count][d] = 0;
                  vector_open = 1;
               end
               stored_value[stored_count][r.dim_index] = r.value;
               stored_weight[stored_count] = r.weight;
               stored_class[stored_count] = r.class_index;
               if (r.end_of_vector) begin
                  stored_count++;
                  vector_open = 0;
               end
            end
         end
         KIND_FINISH: begin
            nd = clamp_1_4(cfg_shadow.dims_used);
            nc = clamp_1_4(cfg_shadow.class_count);
            for (int d = 0; d < 4; d++)
               for (int t = 0; t < 4; t++) imputation_table[d][t] = 0;
            is_trained = cfg_shadow.range_enable;
            if (cfg_shadow.range_enable) begin
               cl_n = cfg_shadow.class_blind ? 1 : nc;
               for (int d = 0; d < nd; d++) begin
                  for (int k = 0; k < cl_n; k++) begin
                     v = 0;
                     if (store_overflowed) st = STATUS_OVERFLOW;
                     else st = impute_entry(d, k, cfg_shadow.class_blind, v);
                     if (st != STATUS_OK) v = 0;
                     if (cfg_shadow.class_blind) begin
                        for (int t = 0; t < nc; t++) imputation_table[d][t] = v;
                     end else begin
                        imputation_table[d][k] = v;
                     end
                     o.result_value = v;
                     o.result_dim = 2'(d);
                     o.result_class = 2'(k);
                     o.status = st;
                     o.last = (d == nd - 1) && (k == cl_n - 1);
                     fresh_results.insert(fresh_results.size(), o);
                  end
               end
            end
            stored_count = 0;
            store_overflowed = 0;
            vector_open = 0;
         end
         KIND_APPLY: begin
            o.result_value = r.value;
            if (is_trained && cfg_shadow.range_enable && !in_valid_range(r.value)) begin
               c = cfg_shadow.class_blind ? 0 : cfg_shadow.chosen_class;
               if (c >= clamp_1_4(cfg_shadow.class_count)) c = 0;
               o.result_value = imputation_table[r.dim_index][c];
            end
            o.result_dim = r.dim_index;
            o.result_class = 0;
            o.status = STATUS_OK;
            o.last = r.end_of_vector;
            fresh_results.insert(fresh_results.size(), o);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(req_type r, bit typed = 0, rsp_type typed_rsp = '0);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(r);
      if (typed) begin
         awaited_results.insert(awaited_results.size(), typed_rsp);
      end else begin
         foreach (fresh_results[i])
            awaited_results.insert(awaited_results.size(), fresh_results[i]);
      end
      fresh_results.delete();
      items_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      do begin
         repeat (20) @(posedge clock);
      end while (busy || awaited_results.size() != 0);
   endtask

   task automatic write_register(reg_index_type idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MODE:         cfg_shadow.mode = val[0];
         REG_CLASS_BLIND:  cfg_shadow.class_blind = val[0];
         REG_CLASS_COUNT:  cfg_shadow.class_count = val[2:0];
         REG_CHOSEN_CLASS: cfg_shadow.chosen_class = val[1:0];
         REG_DIMS_USED:    cfg_shadow.dims_used = val[2:0];
         REG_RANGE_ENABLE: cfg_shadow.range_enable = val[0];
         REG_RANGE_LOW:    cfg_shadow.range_low = val;
         REG_RANGE_HIGH:   cfg_shadow.range_high = val;
         default: ;
      endcase
   endtask

   function automatic req_type make_req(kind_type k, logic [1:0] d, logic [31:0] v,
                                        logic [31:0] w, logic [1:0] c, logic e);
      req_type r;
      r.kind = k;
      r.dim_index = d;
      r.value = v;
      r.weight = w;
      r.class_index = c;
      r.end_of_vector = e;
      return r;
   endfunction

   function automatic step_type item_row(kind_type k, logic [1:0] d, logic [31:0] v,
                                         logic [31:0] w, logic [1:0] c, logic e);
      step_type s;
      s.is_csr = 0;
      s.reg_idx = REG_MODE;
      s.csr_val = 0;
      s.req = make_req(k, d, v, w, c, e);
      s.typed = 0;
      s.rsp = '0;
      return s;
   endfunction

   function automatic step_type reg_row(reg_index_type idx, logic [31:0] val);
      step_type s;
      s = item_row(KIND_NONE, 0, 0, 0, 0, 0);
      s.is_csr = 1;
      s.reg_idx = idx;
      s.csr_val = val;
      return s;
   endfunction

   // Pass-through rows after reset have their result written out.
   function automatic step_type passed_row(logic [1:0] d, logic [31:0] v, logic [31:0] w,
                                           logic [1:0] c, logic e);
      step_type s;
      s = item_row(KIND_APPLY, d, v, w, c, e);
      s.typed = 1;
      s.rsp.result_value = v;
      s.rsp.result_dim = d;
      s.rsp.result_class = 0;
      s.rsp.status = STATUS_OK;
      s.rsp.last = e;
      return s;
   endfunction

   localparam int SCRIPT_ROWS = 30;

   function automatic step_type script_row(int i);
      case (i)
         0:  return passed_row(3, 32'h8000_0000, 32'hFFFF_FFFF, 3, 1);
         1:  return passed_row(0, 32'h7FFF_FFFF, 32'h0, 0, 0);
         2:  return item_row(KIND_NONE, 1, 32'h1234_5678, ONE, 1, 1);
         3:  return item_row(KIND_FINISH, 0, 0, 0, 0, 0);
         4:  return passed_row(2, 32'h0000_0000, ONE, 0, 1);
         5:  return reg_row(REG_RANGE_LOW, 32'hFFF8_0000);
         6:  return reg_row(REG_RANGE_HIGH, 32'h0008_0000);
         7:  return reg_row(REG_RANGE_ENABLE, 1);
         8:  return item_row(KIND_TRAIN, 0, ONE, ONE, 0, 0);
         9:  return item_row(KIND_TRAIN, 1, 32'hFFFE_0000, ONE, 0, 1);
         10: return item_row(KIND_TRAIN, 0, 3 * ONE, 5, 1, 0);
         11: return item_row(KIND_TRAIN, 2, ONE / 2, 2 * ONE, 1, 1);
         12: return item_row(KIND_TRAIN, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 2, 0);
         13: return item_row(KIND_TRAIN, 3, 32'h8000_0000, 32'hFFFF_FFFF, 2, 1);
         14: return item_row(KIND_TRAIN, 1, 4 * ONE, 0, 3, 1);
         15: return item_row(KIND_TRAIN, 0, 5 * ONE, ONE, 0, 0);
         16: return item_row(KIND_FINISH, 0, 0, 0, 0, 0);
         17: return item_row(KIND_APPLY, 0, 32'h8000_0000, 0, 0, 0);
         18: return item_row(KIND_APPLY, 1, ONE, 0, 0, 0);
         19: return item_row(KIND_APPLY, 3, 32'h7FFF_FFFF, 0, 0, 1);
         20: return reg_row(REG_MODE, 1);
         21: return reg_row(REG_CLASS_BLIND, 0);
         22: return reg_row(REG_CLASS_COUNT, 4);
         23: return reg_row(REG_CHOSEN_CLASS, 3);
         24: return item_row(KIND_TRAIN, 0, 2 * ONE, ONE, 3, 1);
         25: return item_row(KIND_TRAIN, 0, 32'hFFF9_0000, 3 * ONE, 3, 1);
         26: return item_row(KIND_TRAIN, 0, 32'hFFFF_0000, 0, 1, 1);
         27: return item_row(KIND_FINISH, 0, 0, 0, 0, 0);
         28: return item_row(KIND_APPLY, 0, 32'h0008_0000, 0, 0, 1);
         default: return reg_row(REG_MODE, 0);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      longint lo;
      longint hi;
      longint span;
      lo = longint'($signed(cfg_shadow.range_low)) + 1;
      hi = longint'($signed(cfg_shadow.range_high)) - 1;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return cfg_shadow.range_low;
         2: return cfg_shadow.range_high;
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: begin
            if (lo > hi) return $urandom;
            span = hi - lo + 1;
            if ($urandom_range(0, 1) && span > 64) span = 64;
            return 32'(lo + longint'({$urandom, $urandom} % span));
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return 0;
         1, 2, 3: return $urandom;
         default: return $urandom_range(1, 4 * ONE);
      endcase
   endfunction

   task automatic random_settings();
      logic [31:0] a;
      logic [31:0] b;
      settle();
      write_register(REG_MODE, $urandom_range(0, 1));
      write_register(REG_CLASS_BLIND, $urandom_range(0, 1));
      write_register(REG_CLASS_COUNT, $urandom_range(0, 7));
      write_register(REG_CHOSEN_CLASS, $urandom_range(0, 3));
      write_register(REG_DIMS_USED, $urandom_range(0, 7));
      write_register(REG_RANGE_ENABLE, $urandom_range(0, 9) != 0);
      case ($urandom_range(0, 3))
         0: begin
            a = 32'h8000_0000;
            b = 32'h7FFF_FFFF;
         end
         1: begin
            a = -($urandom_range(1, 64) * ONE);
            b = $urandom_range(1, 64) * ONE;
         end
         2: begin
            a = $urandom_range(0, 20);
            b = a + $urandom_range(2, 12);
         end
         default: begin
            a = $urandom;
            b = $urandom;
         end
      endcase
      write_register(REG_RANGE_LOW, a);
      write_register(REG_RANGE_HIGH, b);
   endtask

   task automatic random_round();
      int          nvec;
      logic [1:0]  cls;
      logic [31:0] w;
      bit          closed;
      nvec = $urandom_range(0, 10);
      for (int n = 0; n < nvec; n++) begin
         cls = 2'($urandom_range(0, 3));
         closed = $urandom_range(0, 9) != 0;
         for (int d = 0; d < 4; d++) begin
            if (d != 3 && $urandom_range(0, 4) == 0) continue;
            w = pick_weight();
            if ($urandom_range(0, 19) == 0)
               send_item(make_req(KIND_NONE, 2'($urandom), $urandom, $urandom,
                                  2'($urandom), 1));
            send_item(make_req(KIND_TRAIN, 2'(d), pick_value(), w, cls, d == 3 && closed));
         end
      end
      if ($urandom_range(0, 9) != 0) send_item(make_req(KIND_FINISH, 0, 0, 0, 0, 0));
      repeat ($urandom_range(1, 8))
         send_item(make_req(KIND_APPLY, 2'($urandom), pick_value(), $urandom, 2'($urandom),
                            1'($urandom_range(0, 1))));
   endtask

   initial begin
      step_type s;
      int       target;
      cfg_shadow = '0;
      cfg_shadow.class_blind = 1;
      cfg_shadow.class_count = 1;
      cfg_shadow.dims_used = 4;
      stored_count = 0;
      is_trained = 0;
      store_overflowed = 0;
      vector_open = 0;
      for (int d = 0; d < 4; d++)
         for (int t = 0; t < 4; t++) imputation_table[d][t] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         s = script_row(i);
         if (s.is_csr) begin
            settle();
            write_register(s.reg_idx, s.csr_val);
         end else begin
            send_item(s.req, s.typed, s.rsp);
         end
      end

      items_sent = 0;
      for (int p = 0; p < 3; p++) begin
         idle_pct = (p == 0) ? 30 : (p == 1) ? 60 : 0;
         target = (p + 1) * RANDOM_ITEMS / 3;
         while (items_sent < target) begin
            random_settings();
            for (int r = 0; r < 3 && items_sent < target; r++) random_round();
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
sv/mvi_pkg.sv
sv/mvi_csr.sv
sv/mvi_ctrl.sv
sv/mvi_datapath.sv
sv/missing_value_imputer_top.sv
sv/mvi_checker.sv
test/missing_value_imputer_top_test.sv
